// ===== rtl/ryx_pkg.sv =====
// ryx_pkg: widths, matrix coefficients and pipeline types for the rgb-to-yxy converter
// depends on nothing; used by the interfaces and all rtl modules
package ryx_pkg;

   localparam int CompW  = 24;               // q8.16 color component
   localparam int CoefW  = 16;               // q0.16 coefficient
   localparam int ProdW  = CompW + CoefW;    // one product
   localparam int SumW   = ProdW + 1;        // one of x, y, z
   localparam int WsumW  = SumW + 1;         // x + y + z
   localparam int ChromW = 16;               // q0.16 chromaticity
   localparam int QuotW  = ChromW + 1;       // rounded ratio can reach 65536
   localparam int NumW   = SumW + ChromW + 1; // shifted numerator plus half divisor
   localparam int RemW   = WsumW;
   localparam int LowW   = QuotW;            // numerator bits shifted in one per step
   localparam int Steps  = QuotW;

   typedef logic [CoefW-1:0] coef_type;
   localparam coef_type Coef [3][3] = '{
      '{16'd27031, 16'd23434, 16'd11824},
      '{16'd13938, 16'd46869, 16'd4730},
      '{16'd1267,  16'd7811,  16'd62274}
   };

   typedef struct packed {
      logic [CompW-1:0] red;
      logic [CompW-1:0] green;
      logic [CompW-1:0] blue;
   } pixel_type;

   // matrix output handed to the divider
   typedef struct packed {
      logic [SumW-1:0]  sum_x;
      logic [SumW-1:0]  sum_y;
      logic [WsumW-1:0] sum_w;
      logic [CompW-1:0] luma;
      logic             zero;
   } xyz_type;

   // one divider stage, both ratios side by side
   typedef struct packed {
      logic [RemW-1:0]  den;
      logic [RemW-1:0]  rem_x;
      logic [RemW-1:0]  rem_y;
      logic [LowW-1:0]  low_x;
      logic [LowW-1:0]  low_y;
      logic [QuotW-1:0] quo_x;
      logic [QuotW-1:0] quo_y;
      logic [CompW-1:0] luma;
      logic             zero;
   } div_type;

endpackage

// ===== rtl/ryx_if.sv =====
// ryx_req_if / ryx_rsp_if: valid-ready channels carrying pixels in and yxy items out
// depends on ryx_pkg
interface ryx_req_if;
   import ryx_pkg::*;
   logic             valid;
   logic             ready;
   logic [CompW-1:0] red;
   logic [CompW-1:0] green;
   logic [CompW-1:0] blue;
   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

interface ryx_rsp_if;
   import ryx_pkg::*;
   logic              valid;
   logic              ready;
   logic [CompW-1:0]  luma_y;
   logic [ChromW-1:0] chroma_x;
   logic [ChromW-1:0] chroma_y;
   logic              zero_sum;
   modport source (output valid, luma_y, chroma_x, chroma_y, zero_sum, input ready);
   modport sink   (input valid, luma_y, chroma_x, chroma_y, zero_sum, output ready);
endinterface

// ===== rtl/ryx_matrix.sv =====
// ryx_matrix: 3x3 matrix in three stages (products, row sums, total and luma)
// depends on ryx_pkg
module ryx_matrix (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  logic               in_valid,
   input  ryx_pkg::pixel_type in_pixel,
   output logic               out_valid,
   output ryx_pkg::xyz_type   out_xyz
);
   import ryx_pkg::*;

   logic [2:0]            valid_ff, valid_in;
   logic [ProdW-1:0]      prod_ff [3][3];
   logic [ProdW-1:0]      prod_in [3][3];
   logic [SumW-1:0]       sum_ff [3];
   logic [SumW-1:0]       sum_in [3];
   xyz_type               xyz_ff, xyz_in;
   logic [CompW-1:0]      comp [3];
   logic [SumW-1:0]       luma_round;

   assign comp[0] = in_pixel.red;
   assign comp[1] = in_pixel.green;
   assign comp[2] = in_pixel.blue;

   assign valid_in = {valid_ff[1:0], in_valid};

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[r][c] = ProdW'(comp[c]) * ProdW'(Coef[r][c]);
         end
         sum_in[r] = SumW'(prod_ff[r][0]) + SumW'(prod_ff[r][1]) + SumW'(prod_ff[r][2]);
      end
   end

   always_comb begin
      // round half up to q8.16 and clamp to 24 bits
      luma_round        = sum_ff[1] + SumW'(32768);
      xyz_in.sum_x      = sum_ff[0];
      xyz_in.sum_y      = sum_ff[1];
      xyz_in.sum_w      = WsumW'(sum_ff[0]) + WsumW'(sum_ff[1]) + WsumW'(sum_ff[2]);
      xyz_in.luma       = (luma_round[SumW-1:CompW+16] != '0) ? '1
                                                               : luma_round[CompW+15:16];
      xyz_in.zero       = (xyz_in.sum_w == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= prod_in;
         sum_ff  <= sum_in;
         xyz_ff  <= xyz_in;
      end
   end

   assign out_valid = valid_ff[2];
   assign out_xyz   = xyz_ff;

endmodule

// ===== rtl/ryx_div_step.sv =====
// ryx_div_step: one restoring-division step for both ratios, one quotient bit each
// depends on ryx_pkg
module ryx_div_step (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   input  ryx_pkg::div_type  in_div,
   output logic              out_valid,
   output ryx_pkg::div_type  out_div
);
   import ryx_pkg::*;

   logic      valid_ff;
   div_type   div_ff, div_in;
   logic [RemW:0] trial_x, trial_y;
   logic [RemW:0] diff_x, diff_y;

   always_comb begin
      trial_x = {in_div.rem_x, in_div.low_x[LowW-1]};
      trial_y = {in_div.rem_y, in_div.low_y[LowW-1]};
      diff_x  = trial_x - {1'b0, in_div.den};
      diff_y  = trial_y - {1'b0, in_div.den};
      div_in  = in_div;
      div_in.low_x = {in_div.low_x[LowW-2:0], 1'b0};
      div_in.low_y = {in_div.low_y[LowW-2:0], 1'b0};
      // remainder stays below the divisor, so it always fits back in RemW bits
      if (!diff_x[RemW]) begin
         div_in.rem_x = diff_x[RemW-1:0];
         div_in.quo_x = {in_div.quo_x[QuotW-2:0], 1'b1};
      end else begin
         div_in.rem_x = trial_x[RemW-1:0];
         div_in.quo_x = {in_div.quo_x[QuotW-2:0], 1'b0};
      end
      if (!diff_y[RemW]) begin
         div_in.rem_y = diff_y[RemW-1:0];
         div_in.quo_y = {in_div.quo_y[QuotW-2:0], 1'b1};
      end else begin
         div_in.rem_y = trial_y[RemW-1:0];
         div_in.quo_y = {in_div.quo_y[QuotW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         div_ff <= div_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_div   = div_ff;

endmodule

// ===== rtl/ryx_divider.sv =====
// ryx_divider: rounding setup stage and a chain of division steps for x/w and y/w
// depends on ryx_pkg, ryx_div_step
module ryx_divider (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   input  ryx_pkg::xyz_type  in_xyz,
   output logic              out_valid,
   output ryx_pkg::div_type  out_div
);
   import ryx_pkg::*;

   logic            setup_valid_ff;
   div_type         setup_ff, setup_in;
   logic [NumW-1:0] num_x, num_y;
   logic            step_valid [Steps+1];
   div_type         step_div   [Steps+1];

   always_comb begin
      // numerator << 16 plus half the divisor gives round half up
      num_x = {1'b0, in_xyz.sum_x, ChromW'(0)} + NumW'(in_xyz.sum_w >> 1);
      num_y = {1'b0, in_xyz.sum_y, ChromW'(0)} + NumW'(in_xyz.sum_w >> 1);
      setup_in.den   = in_xyz.sum_w;
      setup_in.rem_x = RemW'(num_x[NumW-1:LowW]);
      setup_in.rem_y = RemW'(num_y[NumW-1:LowW]);
      setup_in.low_x = num_x[LowW-1:0];
      setup_in.low_y = num_y[LowW-1:0];
      setup_in.quo_x = '0;
      setup_in.quo_y = '0;
      setup_in.luma  = in_xyz.luma;
      setup_in.zero  = in_xyz.zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setup_valid_ff <= 1'b0;
      end else if (enable) begin
         setup_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         setup_ff <= setup_in;
      end
   end

   assign step_valid[0] = setup_valid_ff;
   assign step_div[0]   = setup_ff;

   for (genvar i = 0; i < Steps; i++) begin : g_step
      ryx_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .in_valid  (step_valid[i]),
         .in_div    (step_div[i]),
         .out_valid (step_valid[i+1]),
         .out_div   (step_div[i+1])
      );
   end

   assign out_valid = step_valid[Steps];
   assign out_div   = step_div[Steps];

endmodule

// ===== rtl/rgb_to_yxy_convert.sv =====
// rgb_to_yxy_convert: top level, linear rgb q8.16 to luminance y and chromaticity x, y
// depends on ryx_pkg, ryx_if, ryx_matrix, ryx_divider
//
//   channel    dir  handshake     payload
//   req_chan   in   valid/ready   red, green, blue (24b each)
//   rsp_chan   out  valid/ready   luma_y (24b), chroma_x, chroma_y (16b), zero_sum
//
// one item per cycle while the output is taken; 3 matrix stages, a rounding setup
// stage, 17 division steps (one quotient bit each) and the output register.
// reset clears only the valid bits.
// the whole pipeline holds while the output register is full and not taken;
// bubbles are not squeezed out while it waits.
module rgb_to_yxy_convert (
   input logic      clock,
   input logic      reset,
   ryx_req_if.sink  req_chan,
   ryx_rsp_if.source rsp_chan
);
   import ryx_pkg::*;

   logic      enable;
   pixel_type pixel;
   logic      mat_valid;
   xyz_type   mat_xyz;
   logic      div_valid;
   div_type   div_res;

   logic              out_valid_ff, out_valid_in;
   logic [CompW-1:0]  luma_ff, luma_in;
   logic [ChromW-1:0] chrom_x_ff, chrom_x_in;
   logic [ChromW-1:0] chrom_y_ff, chrom_y_in;
   logic              zero_ff, zero_in;

   assign enable         = rsp_chan.ready || !out_valid_ff;
   assign req_chan.ready = enable;
   assign pixel.red      = req_chan.red;
   assign pixel.green    = req_chan.green;
   assign pixel.blue     = req_chan.blue;

   ryx_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (req_chan.valid),
      .in_pixel  (pixel),
      .out_valid (mat_valid),
      .out_xyz   (mat_xyz)
   );

   ryx_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (mat_valid),
      .in_xyz    (mat_xyz),
      .out_valid (div_valid),
      .out_div   (div_res)
   );

   always_comb begin
      out_valid_in = div_valid;
      luma_in      = div_res.luma;
      zero_in      = div_res.zero;
      // a ratio that rounds up to one saturates
      chrom_x_in   = div_res.quo_x[QuotW-1] ? '1 : div_res.quo_x[ChromW-1:0];
      chrom_y_in   = div_res.quo_y[QuotW-1] ? '1 : div_res.quo_y[ChromW-1:0];
      if (div_res.zero) begin
         chrom_x_in = '0;
         chrom_y_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         luma_ff    <= luma_in;
         chrom_x_ff <= chrom_x_in;
         chrom_y_ff <= chrom_y_in;
         zero_ff    <= zero_in;
      end
   end

   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.luma_y   = luma_ff;
   assign rsp_chan.chroma_x = chrom_x_ff;
   assign rsp_chan.chroma_y = chrom_y_ff;
   assign rsp_chan.zero_sum = zero_ff;

`ifndef SYNTH
   a_zero_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.zero_sum |->
         rsp_chan.chroma_x == '0 && rsp_chan.chroma_y == '0 && rsp_chan.luma_y == '0)
      else $error("zero sum item with nonzero fields");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |-> !req_chan.ready)
      else $error("input taken while output stalled");

   a_chroma_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.zero_sum |->
         ({1'b0, rsp_chan.chroma_x} + {1'b0, rsp_chan.chroma_y}) <= 17'd65537)
      else $error("chromaticities sum above one");
`endif

endmodule

// ===== verif/ryx_tb_if.sv =====
`timescale 1ns / 100ps
// testbench-side note: the channel interfaces come from rtl/ryx_if.sv
// this file holds the yxy expectation record shared by the testbench
// depends on ryx_pkg
package ryx_tb_pkg;
   import ryx_pkg::*;

   typedef struct packed {
      logic [CompW-1:0]  luma_y;
      logic [ChromW-1:0] chroma_x;
      logic [ChromW-1:0] chroma_y;
      logic              zero_sum;
   } yxy_type;
endpackage

// ===== verif/tb_rgb_to_yxy_convert.sv =====
`timescale 1ns / 100ps
// tb_rgb_to_yxy_convert: drives pixels into the rgb-to-yxy converter and checks every
// yxy item against an in-bench fixed-point model, with random idling on both sides
// depends on ryx_pkg, ryx_tb_pkg, ryx_if and the rtl
module tb_rgb_to_yxy_convert;
   import ryx_pkg::*;
   import ryx_tb_pkg::*;

   localparam int Latency   = 22;
   localparam int IdleLimit = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ryx_req_if req_chan ();
   ryx_rsp_if rsp_chan ();

   rgb_to_yxy_convert u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always #5 clock = ~clock;

   yxy_type yxy_pending[$];
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   int      errors        = 0;
   int      pixels_sent   = 0;
   int      items_checked = 0;
   int      idle_cycles   = 0;

   initial begin
      req_chan.valid = 1'b0;
      req_chan.red   = '0;
      req_chan.green = '0;
      req_chan.blue  = '0;
      rsp_chan.ready = 1'b0;
   end

   function automatic logic [ChromW-1:0] ratio_q16(logic [63:0] num, logic [63:0] den);
      logic [63:0] q;
      if (den == 0) begin
         return '0;
      end
      q = ((num << 16) + (den >> 1)) / den;
      return (q > 64'hFFFF) ? 16'hFFFF : q[ChromW-1:0];
   endfunction

   function automatic yxy_type convert_pixel(logic [CompW-1:0] r, logic [CompW-1:0] g,
                                             logic [CompW-1:0] b);
      logic [63:0] sum_x, sum_y, sum_z, sum_w, lq;
      yxy_type     res;
      sum_x = 64'd27031 * r + 64'd23434 * g + 64'd11824 * b;
      sum_y = 64'd13938 * r + 64'd46869 * g + 64'd4730  * b;
      sum_z = 64'd1267  * r + 64'd7811  * g + 64'd62274 * b;
      sum_w = sum_x + sum_y + sum_z;
      lq    = (sum_y + 64'h8000) >> 16;
      res.luma_y = (lq > 64'hFFFFFF) ? 24'hFFFFFF : lq[CompW-1:0];
      if (sum_w == 0) begin
         res.chroma_x = '0;
         res.chroma_y = '0;
         res.zero_sum = 1'b1;
      end else begin
         res.chroma_x = ratio_q16(sum_x, sum_w);
         res.chroma_y = ratio_q16(sum_y, sum_w);
         res.zero_sum = 1'b0;
      end
      return res;
   endfunction

   // one pixel, held until the converter takes it
   task automatic send_pixel(logic [CompW-1:0] r, logic [CompW-1:0] g, logic [CompW-1:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         @(posedge clock);
         @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.red   = r;
      req_chan.green = g;
      req_chan.blue  = b;
      do @(posedge clock); while (!req_chan.ready);
      yxy_pending.push_back(convert_pixel(r, g, b));
      pixels_sent++;
      @(negedge clock);
      req_chan.valid = 1'b0;
   endtask

   task automatic wait_drained();
      while (yxy_pending.size() != 0) @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (!reset) begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      yxy_type got, want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = '{rsp_chan.luma_y, rsp_chan.chroma_x, rsp_chan.chroma_y, rsp_chan.zero_sum};
         if (yxy_pending.size() == 0) begin
            $display("%0t: unexpected yxy item %h", $time, got);
            errors++;
         end else begin
            want = yxy_pending.pop_front();
            items_checked++;
            if (got.luma_y !== want.luma_y)
               $display("%0t: luma_y expected %h actual %h", $time, want.luma_y, got.luma_y);
            if (got.chroma_x !== want.chroma_x)
               $display("%0t: chroma_x expected %h actual %h", $time, want.chroma_x,
                        got.chroma_x);
            if (got.chroma_y !== want.chroma_y)
               $display("%0t: chroma_y expected %h actual %h", $time, want.chroma_y,
                        got.chroma_y);
            if (got.zero_sum !== want.zero_sum)
               $display("%0t: zero_sum expected %b actual %b", $time, want.zero_sum,
                        got.zero_sum);
            if (got !== want) errors++;
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || reset) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("FAIL rgb_to_yxy_convert");
            $finish;
         end
      end
   end

   task automatic test_directed();
      send_pixel('0, '0, '0);
      send_pixel('1, '1, '1);
      send_pixel('1, '0, '0);
      send_pixel('0, '1, '0);
      send_pixel('0, '0, '1);
      send_pixel(24'd1, 24'd0, 24'd0);
      send_pixel(24'd0, 24'd1, 24'd0);
      send_pixel(24'd0, 24'd0, 24'd1);
      send_pixel(24'h010000, 24'h010000, 24'h010000);
      send_pixel(24'hFFFFFF, 24'd0, 24'd0);
      send_pixel(24'd0, 24'hFFFFFF, 24'hFFFFFF);
      send_pixel(24'hAAAAAA, 24'h555555, 24'hAAAAAA);
      send_pixel(24'h555555, 24'hAAAAAA, 24'h555555);
      send_pixel(24'd0, 24'h800000, 24'd1);
      send_pixel(24'd1, 24'hFFFFFF, 24'd0);
      wait_drained();
   endtask

   task automatic test_random(int count);
      logic [CompW-1:0] c[3];
      repeat (count) begin
         for (int i = 0; i < 3; i++) begin
            case ($urandom_range(5))
               0: c[i] = '0;
               1: c[i] = '1;
               2: c[i] = CompW'($urandom_range(255));
               3: c[i] = CompW'($urandom_range(24'h3FFFF));
               default: c[i] = CompW'($urandom());
            endcase
         end
         send_pixel(c[0], c[1], c[2]);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      send_idle_pct = 32;
      recv_idle_pct = 45;
      test_directed();
      test_random(480);
      // hold off until the pipeline is empty, then continue
      wait_drained();
      send_idle_pct = 45;
      recv_idle_pct = 32;
      test_random(480);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(480);
      wait_drained();
      repeat (Latency + 4) @(posedge clock);
      $display("sent %0d pixels, checked %0d yxy items over three idling mixes",
               pixels_sent, items_checked);
      if (errors == 0 && yxy_pending.size() == 0) begin
         $display("PASS rgb_to_yxy_convert");
      end else begin
         $display("FAIL rgb_to_yxy_convert");
      end
      $finish;
   end
endmodule
